// ===== hdl/seep_pkg.sv =====
// shared types, codes and reset values for the serial eeprom command engine
// no dependencies; imported by every module of the block
`default_nettype none

package seep_pkg;

  // array size default and pointer width
  localparam int unsigned MEM_BYTES_DEF = 65536;
  localparam int unsigned PTR_W = 24;

  // request function codes
  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_READ    = 2'd1;
  localparam logic [1:0] FN_POLL    = 2'd2;
  localparam logic [1:0] FN_RELEASE = 2'd3;

  // opcodes accepted in standby
  localparam logic [7:0] OP_WRSR   = 8'h01;
  localparam logic [7:0] OP_RDSR   = 8'h05;
  localparam logic [7:0] OP_LPWP   = 8'h08;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_WRDI   = 8'h04;
  localparam logic [7:0] OP_RDID   = 8'h9f;
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_BYTEWR = 8'h02;
  localparam logic [7:0] OP_ARRWR  = 8'h07;
  localparam logic [7:0] OP_QOFR   = 8'h6B;

  // write-enable latch in the status register
  localparam logic [7:0] WEL_BIT = 8'h02;

  // configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_ID_FIRST    = 2'd0;
  localparam logic [1:0] REG_ID_SECOND   = 2'd1;
  localparam logic [1:0] REG_ID_THIRD    = 2'd2;
  localparam logic [1:0] REG_BUSY_RELOAD = 2'd3;

  // configuration reset values
  localparam logic [7:0] ID_FIRST_RST    = 8'd194;
  localparam logic [7:0] ID_SECOND_RST   = 8'd32;
  localparam logic [7:0] ID_THIRD_RST    = 8'd22;
  localparam logic [7:0] BUSY_RELOAD_RST = 8'd10;

  typedef struct packed {
    logic [7:0] id_first;
    logic [7:0] id_second;
    logic [7:0] id_third;
    logic [7:0] busy_reload;
  } cfg_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fault;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/seep_ram.sv =====
// byte array: single-port synchronous ram with registered read data
// read data holds until the next read; depends on seep_pkg
`default_nettype none

module seep_ram
  import seep_pkg::*;
#(
  parameter int unsigned DEPTH = MEM_BYTES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/seep_cmd.sv =====
// command state machine: opcode decode, address assembly, pointer, latch,
// status and busy count; drives the byte array port; depends on seep_pkg
`default_nettype none

module seep_cmd
  import seep_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF,
  localparam int unsigned AW = $clog2(MEM_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [1:0]    func,
  input  wire logic [7:0]    data_byte,
  input  wire cfg_t          cfg,
  output res_t               res,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [7:0]         mem_wdata,
  input  wire logic [7:0]    mem_rdata
);

  typedef enum logic [2:0] {
    ST_STANDBY,
    ST_WRSR,
    ST_RDSR,
    ST_RDID,
    ST_READ,
    ST_BYTEWR,
    ST_ARRWR,
    ST_QOFR
  } state_t;

  localparam logic [AW+1:0] M_X = (AW+2)'(MEM_BYTES);
  localparam logic [AW:0]   M_W = (AW+1)'(MEM_BYTES);

  // elaboration-time residue of a 24-bit value
  function automatic logic [PTR_W-1:0] mod_const(input logic [PTR_W-1:0] x);
    logic [PTR_W:0] r;
    r = '0;
    for (int i = PTR_W - 1; i >= 0; i--) begin
      r = {r[PTR_W-1:0], x[i]};
      if (r >= (PTR_W+1)'(MEM_BYTES)) begin
        r = r - (PTR_W+1)'(MEM_BYTES);
      end
    end
    return r[PTR_W-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
    logic [AW:0] n;
    n = {1'b0, a} + (AW+1)'(1);
    return (n == M_W) ? '0 : n[AW-1:0];
  endfunction

  state_t           cmd_state, cmd_state_next;
  logic [1:0]       phase_count, phase_count_next;
  logic [PTR_W-1:0] byte_pointer, byte_pointer_next;
  logic [7:0]       out_latch, out_latch_next;
  logic             latch_pend, latch_pend_next;
  logic [7:0]       busy_count, busy_count_next;
  logic [7:0]       status_reg, status_reg_next;

  logic [7:0]       eff_latch;
  logic [PTR_W-1:0] addr_shift;
  logic [PTR_W-1:0] assembled;
  logic [PTR_W-1:0] mod_in;
  logic [AW+1:0]    msum, mred1, mred2;
  logic [AW-1:0]    mod_out;
  logic [AW-1:0]    nxt_idx;

  // residue tables for the upper two pointer bytes
  logic [AW-1:0] t_hi  [256];
  logic [AW-1:0] t_mid [256];

  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign t_hi[g]  = AW'(mod_const(PTR_W'(g) << 16));
    assign t_mid[g] = AW'(mod_const(PTR_W'(g) << 8));
  end

  // latch loaded from the array resolves in the cycle after the read
  assign eff_latch = latch_pend ? mem_rdata : out_latch;

  always_comb begin
    case (phase_count)
      2'd0:    addr_shift = {data_byte, 16'h0000};
      2'd1:    addr_shift = {8'h00, data_byte, 8'h00};
      default: addr_shift = {16'h0000, data_byte};
    endcase
  end

  assign assembled = byte_pointer | addr_shift;
  assign mod_in    = (func == FN_WRITE) ? assembled : byte_pointer;

  // pointer modulo array size: table sum then two conditional subtracts
  assign msum = (AW+2)'(t_hi[mod_in[23:16]]) + (AW+2)'(t_mid[mod_in[15:8]])
              + (AW+2)'(mod_in[7:0]);
  assign mred1   = (msum >= M_X) ? msum - M_X : msum;
  assign mred2   = (mred1 >= M_X) ? mred1 - M_X : mred1;
  assign mod_out = mred2[AW-1:0];
  assign nxt_idx = inc_wrap(mod_out);

  always_comb begin
    cmd_state_next    = cmd_state;
    phase_count_next  = phase_count;
    byte_pointer_next = byte_pointer;
    out_latch_next    = out_latch;
    latch_pend_next   = latch_pend;
    busy_count_next   = busy_count;
    status_reg_next   = status_reg;
    res.read_data     = 8'h00;
    res.fault         = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_addr          = byte_pointer[AW-1:0];
    mem_wdata         = data_byte;

    if (step) begin
      case (func)
        FN_WRITE: begin
          case (cmd_state)
            ST_STANDBY: begin
              case (data_byte)
                OP_WRSR: begin
                  cmd_state_next  = ST_WRSR;
                  status_reg_next = 8'h00;
                end
                OP_RDSR: begin
                  out_latch_next  = status_reg;
                  latch_pend_next = 1'b0;
                  cmd_state_next  = ST_RDSR;
                end
                OP_LPWP: begin
                  out_latch_next  = (busy_count != 8'h00) ? 8'h01 : 8'h00;
                  latch_pend_next = 1'b0;
                  if (busy_count != 8'h00) begin
                    busy_count_next = busy_count - 8'h01;
                  end
                end
                OP_WREN: status_reg_next = status_reg | WEL_BIT;
                OP_WRDI: status_reg_next = status_reg & ~WEL_BIT;
                OP_RDID: begin
                  out_latch_next   = cfg.id_first;
                  latch_pend_next  = 1'b0;
                  cmd_state_next   = ST_RDID;
                  phase_count_next = 2'd0;
                end
                OP_READ, OP_BYTEWR, OP_ARRWR, OP_QOFR: begin
                  case (data_byte)
                    OP_READ:   cmd_state_next = ST_READ;
                    OP_BYTEWR: cmd_state_next = ST_BYTEWR;
                    OP_ARRWR:  cmd_state_next = ST_ARRWR;
                    default:   cmd_state_next = ST_QOFR;
                  endcase
                  phase_count_next  = 2'd0;
                  byte_pointer_next = '0;
                  busy_count_next   = 8'h00;
                end
                default: res.fault = 1'b1;
              endcase
            end
            ST_WRSR: begin
              status_reg_next  = data_byte;
              cmd_state_next   = ST_STANDBY;
              phase_count_next = 2'd0;
            end
            ST_READ, ST_BYTEWR, ST_ARRWR, ST_QOFR: begin
              if (phase_count == 2'd3) begin
                if (cmd_state == ST_BYTEWR) begin
                  mem_we           = 1'b1;
                  cmd_state_next   = ST_STANDBY;
                  phase_count_next = 2'd0;
                end else if (cmd_state == ST_ARRWR) begin
                  mem_we            = 1'b1;
                  byte_pointer_next = PTR_W'(inc_wrap(byte_pointer[AW-1:0]));
                end else begin
                  res.fault = 1'b1;
                end
              end else begin
                // address byte, most significant first
                byte_pointer_next = assembled;
                phase_count_next  = phase_count + 2'd1;
                busy_count_next   = cfg.busy_reload;
                if (phase_count == 2'd2) begin
                  byte_pointer_next = PTR_W'(mod_out);
                  if (cmd_state == ST_READ) begin
                    mem_re          = 1'b1;
                    mem_addr        = mod_out;
                    latch_pend_next = 1'b1;
                  end
                end
              end
            end
            default: res.fault = 1'b1;
          endcase
        end
        FN_READ: begin
          res.read_data = eff_latch;
          case (cmd_state)
            ST_READ, ST_QOFR: begin
              byte_pointer_next = PTR_W'(nxt_idx);
              mem_re            = 1'b1;
              mem_addr          = nxt_idx;
              latch_pend_next   = 1'b1;
              busy_count_next   = cfg.busy_reload;
            end
            ST_RDSR: cmd_state_next = ST_STANDBY;
            ST_RDID: begin
              case (phase_count)
                2'd0:    out_latch_next = cfg.id_second;
                2'd1:    out_latch_next = cfg.id_third;
                default: out_latch_next = 8'h00;
              endcase
              latch_pend_next = 1'b0;
              if (phase_count >= 2'd2) begin
                cmd_state_next   = ST_STANDBY;
                phase_count_next = 2'd0;
              end else begin
                phase_count_next = phase_count + 2'd1;
              end
            end
            default: begin
              out_latch_next  = 8'h00;
              latch_pend_next = 1'b0;
              res.fault       = 1'b1;
            end
          endcase
        end
        FN_POLL: begin
          res.read_data = (busy_count != 8'h00) ? 8'h01 : 8'h00;
          if (busy_count != 8'h00) begin
            busy_count_next = busy_count - 8'h01;
          end
        end
        default: begin
          byte_pointer_next = '1;
          cmd_state_next    = ST_STANDBY;
          phase_count_next  = 2'd0;
          out_latch_next    = 8'h00;
          latch_pend_next   = 1'b0;
          busy_count_next   = 8'h00;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_state    <= ST_STANDBY;
      phase_count  <= 2'd0;
      byte_pointer <= '1;
      out_latch    <= 8'h00;
      latch_pend   <= 1'b0;
      busy_count   <= 8'h00;
      status_reg   <= 8'h00;
    end else begin
      cmd_state    <= cmd_state_next;
      phase_count  <= phase_count_next;
      byte_pointer <= byte_pointer_next;
      out_latch    <= out_latch_next;
      latch_pend   <= latch_pend_next;
      busy_count   <= busy_count_next;
      status_reg   <= status_reg_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spi_eeprom_command_engine.sv =====
// top level of the serial eeprom command engine: request/result channels,
// configuration registers and output register; depends on seep_pkg,
// seep_cmd and seep_ram
`default_nettype none

// Serial EEPROM slave model that takes one bus access per request: a command,
// address or data byte written (func 0), a byte read (func 1), a busy poll
// (func 2) or a chip-select release (func 3). Every request gives exactly one
// result (read_data, fault). The engine takes one request per clock cycle; the
// result sits in the output register from the cycle after acceptance, and a
// new request is taken whenever that register is empty or being drained.
// The single-port byte array does not limit the rate: a read or address byte
// that loads the output latch from the array issues an array read, and the
// returned byte is forwarded straight into the next request, so back-to-back
// array reads run at one request per cycle while results drain. The array is
// MEM_BYTES deep (addresses wrap modulo MEM_BYTES) and is not cleared by reset:
// reading a location that was never written returns unknown data.
// Configuration registers (APB, 32-bit data, byte address 4*index): id_first,
// id_second, id_third (RDID bytes) and busy_reload (busy poll count). Write
// them only while the engine is idle.

module spi_eeprom_command_engine
  import seep_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  data_byte,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       read_data,
  output logic             fault,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  cfg_t          cfg;
  res_t          res;
  logic          step;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // take a request when the output register is free or draining this cycle
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  // apb: zero wait states
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_ID_FIRST:  prdata = 32'(cfg.id_first);
      REG_ID_SECOND: prdata = 32'(cfg.id_second);
      REG_ID_THIRD:  prdata = 32'(cfg.id_third);
      default:       prdata = 32'(cfg.busy_reload);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_first    <= ID_FIRST_RST;
      cfg.id_second   <= ID_SECOND_RST;
      cfg.id_third    <= ID_THIRD_RST;
      cfg.busy_reload <= BUSY_RELOAD_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ID_FIRST:  cfg.id_first    <= pwdata[7:0];
        REG_ID_SECOND: cfg.id_second   <= pwdata[7:0];
        REG_ID_THIRD:  cfg.id_third    <= pwdata[7:0];
        default:       cfg.busy_reload <= pwdata[7:0];
      endcase
    end
  end

  // command engine: all command state; the array, configuration and output registers sit outside
  seep_cmd #(
    .MEM_BYTES (MEM_BYTES)
  ) u_cmd (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (func),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res       (res),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // byte array
  seep_ram #(
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // output register: result payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      read_data <= res.read_data;
      fault     <= res.fault;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/seep_chk.sv =====
// port-level checker for the serial eeprom command engine and its bind
// depends on seep_pkg; attached to spi_eeprom_command_engine
`default_nettype none

module seep_chk
  import seep_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       fault
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(fault))
    else $error("result changed while stalled");

  // an empty output register never blocks a request
  a_room: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // busy poll gives a single bit and no fault
  a_poll: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FN_POLL |=>
      out_valid && read_data[7:1] == 7'd0 && !fault)
    else $error("bad busy poll result");

  // chip-select release gives zero and no fault
  a_rel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FN_RELEASE |=>
      out_valid && read_data == 8'd0 && !fault)
    else $error("bad release result");

  // no result straight out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spi_eeprom_command_engine seep_chk u_chk (.*);

`default_nettype wire

// ===== bench/spi_eeprom_command_engine_tb.sv =====
// self-checking bench for the serial eeprom command engine: directed table, then
// random command sequences checked against a cycle-free predictor of the engine
// depends on seep_pkg and spi_eeprom_command_engine
`timescale 1ns / 1ps

module spi_eeprom_command_engine_tb
  import seep_pkg::*;
();

  localparam int unsigned MEM = MEM_BYTES_DEF;
  localparam int STALL_LIMIT = 4000;    // cycles with no handshake before giving up
  localparam int PHASE_REQUESTS = 145;  // random requests per idling phase
  localparam int HOLD_CYCLES = 300;     // long receiver hold-off in the first phase

  // predictor view of the command state
  typedef enum logic [3:0] {
    ENG_STANDBY, ENG_WRSR, ENG_RDSR, ENG_RDID,
    ENG_READ, ENG_BYTEWR, ENG_ARRWR, ENG_QOFR
  } eng_state_t;

  // one row of the directed table; typed rows carry their own expected reply
  typedef struct {
    logic [1:0] f;
    logic [7:0] b;
    bit         typed;
    logic [7:0] rd;
    logic       flt;
  } dir_row_t;

  localparam int DIR_ROWS = 30;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;
  logic        fault;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state and its copy of the configuration registers
  eng_state_t  eng_st;
  logic [1:0]  eng_phase;
  logic [23:0] eng_ptr;
  logic [7:0]  eng_latch;
  logic [7:0]  eng_busy;
  logic [7:0]  eng_status;
  cfg_t        cfg;
  logic [7:0]  mem_img [MEM];
  bit          mem_set [MEM];
  logic [15:0] wr_list [$];   // every array address written so far

  res_t awaited_replies [$];

  // stimulus shaping, each written by one process only
  int snd_pct;
  int rcv_pct;
  int hold_end;
  int rcv_cycle;

  int mismatch_cnt;
  int n_requests;
  int n_faults;
  int n_replies;
  int stall_cycles;

  // directed part: error codes, id bytes, status, wrap at the array end,
  // and a read issued before the address is complete
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FN_WRITE,   OP_LPWP,   1'b1, 8'h00,           1'b0},  // poll bit into latch, not busy
    '{FN_POLL,    8'h00,     1'b1, 8'h00,           1'b0},
    '{FN_READ,    8'hff,     1'b1, 8'h00,           1'b1},  // read in standby
    '{FN_WRITE,   8'hff,     1'b1, 8'h00,           1'b1},  // illegal opcode
    '{FN_WRITE,   OP_RDID,   1'b1, 8'h00,           1'b0},
    '{FN_READ,    8'h00,     1'b1, ID_FIRST_RST,    1'b0},
    '{FN_READ,    8'h00,     1'b1, ID_SECOND_RST,   1'b0},
    '{FN_READ,    8'h00,     1'b1, ID_THIRD_RST,    1'b0},  // third id byte ends rdid
    '{FN_WRITE,   OP_WREN,   1'b1, 8'h00,           1'b0},  // taken as an opcode again
    '{FN_WRITE,   OP_RDSR,   1'b1, 8'h00,           1'b0},
    '{FN_WRITE,   8'h00,     1'b1, 8'h00,           1'b1},  // byte while status is pending
    '{FN_READ,    8'h00,     1'b1, WEL_BIT,         1'b0},
    '{FN_WRITE,   OP_WRSR,   1'b1, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   OP_ARRWR,  1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},  // address folds to the last byte
    '{FN_WRITE,   8'ha5,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'h5a,     1'b0, 8'h00,           1'b0},  // pointer wraps to zero
    '{FN_WRITE,   8'h00,     1'b0, 8'h00,           1'b0},
    '{FN_RELEASE, 8'h00,     1'b1, 8'h00,           1'b0},
    '{FN_WRITE,   OP_READ,   1'b1, 8'h00,           1'b0},
    '{FN_READ,    8'h00,     1'b1, 8'h00,           1'b0},  // read before the address
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_WRITE,   8'hff,     1'b0, 8'h00,           1'b0},
    '{FN_READ,    8'h00,     1'b1, 8'ha5,           1'b0},
    '{FN_READ,    8'h00,     1'b1, 8'h5a,           1'b0},  // wrapped read
    '{FN_RELEASE, 8'hff,     1'b1, 8'h00,           1'b0}
  };

  spi_eeprom_command_engine #(
    .MEM_BYTES(MEM)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .fault(fault),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // pointer step with wrap at the array size
  function automatic logic [23:0] step_pointer(input logic [23:0] p);
    int unsigned n;
    n = (p % MEM) + 1;
    if (n >= MEM) n = 0;
    return n[23:0];
  endfunction

  // false when the request would make the engine fetch an array byte never written
  function automatic bit reads_known_byte(input logic [1:0] f, input logic [7:0] b);
    logic [23:0] full;
    full = eng_ptr | {16'd0, b};
    if (f == FN_READ && (eng_st == ENG_READ || eng_st == ENG_QOFR))
      return mem_set[step_pointer(eng_ptr)];
    if (f == FN_WRITE && eng_st == ENG_READ && eng_phase == 2'd2)
      return mem_set[full % MEM];
    return 1'b1;
  endfunction

  // the engine's reply to one request, advancing the predicted state
  function automatic void eeprom_access(input logic [1:0] f, input logic [7:0] b,
                                        output logic [7:0] rd, output logic flt);
    int unsigned idx;
    rd = 8'h00;
    flt = 1'b0;
    case (f)
      FN_WRITE: begin
        if (eng_st == ENG_STANDBY) begin
          case (b)
            OP_WRSR: begin
              eng_st = ENG_WRSR;
              eng_status = 8'h00;
            end
            OP_RDSR: begin
              eng_latch = eng_status;
              eng_st = ENG_RDSR;
            end
            OP_LPWP: begin
              eng_latch = (eng_busy != 0) ? 8'h01 : 8'h00;
              if (eng_busy != 0) eng_busy--;
            end
            OP_WREN: eng_status = eng_status | WEL_BIT;
            OP_WRDI: eng_status = eng_status & ~WEL_BIT;
            OP_RDID: begin
              eng_latch = cfg.id_first;
              eng_st = ENG_RDID;
              eng_phase = 2'd0;
            end
            OP_READ, OP_BYTEWR, OP_ARRWR, OP_QOFR: begin
              eng_st = (b == OP_READ) ? ENG_READ : (b == OP_BYTEWR) ? ENG_BYTEWR :
                       (b == OP_ARRWR) ? ENG_ARRWR : ENG_QOFR;
              eng_phase = 2'd0;
              eng_ptr = 24'd0;
              eng_busy = 8'd0;
            end
            default: flt = 1'b1;
          endcase
        end else if (eng_st == ENG_WRSR) begin
          eng_status = b;
          eng_st = ENG_STANDBY;
          eng_phase = 2'd0;
        end else if ((eng_st == ENG_BYTEWR || eng_st == ENG_ARRWR) && eng_phase == 2'd3) begin
          idx = eng_ptr % MEM;
          mem_img[idx] = b;
          if (!mem_set[idx]) begin
            mem_set[idx] = 1'b1;
            wr_list.push_back(idx[15:0]);
          end
          if (eng_st == ENG_BYTEWR) begin
            eng_st = ENG_STANDBY;
            eng_phase = 2'd0;
          end else begin
            eng_ptr = step_pointer(eng_ptr);
          end
        end else if ((eng_st == ENG_READ || eng_st == ENG_BYTEWR || eng_st == ENG_ARRWR ||
                      eng_st == ENG_QOFR) && eng_phase != 2'd3) begin
          // address byte, most significant first
          eng_ptr = eng_ptr | ({16'd0, b} << (8 * (2 - eng_phase)));
          eng_phase++;
          if (eng_phase == 2'd3) begin
            eng_ptr = 24'(eng_ptr % MEM);
            if (eng_st == ENG_READ) eng_latch = mem_img[eng_ptr];
          end
          eng_busy = cfg.busy_reload;
        end else begin
          flt = 1'b1;
        end
      end
      FN_READ: begin
        rd = eng_latch;
        case (eng_st)
          ENG_READ, ENG_QOFR: begin
            eng_ptr = step_pointer(eng_ptr);
            eng_latch = mem_img[eng_ptr];
            eng_busy = cfg.busy_reload;
          end
          ENG_RDSR: eng_st = ENG_STANDBY;
          ENG_RDID: begin
            eng_latch = (eng_phase == 2'd0) ? cfg.id_second :
                        (eng_phase == 2'd1) ? cfg.id_third : 8'h00;
            eng_phase++;
            if (eng_phase == 2'd3) begin
              eng_st = ENG_STANDBY;
              eng_phase = 2'd0;
            end
          end
          default: begin
            eng_latch = 8'h00;
            flt = 1'b1;
          end
        endcase
      end
      FN_POLL: begin
        rd = (eng_busy != 0) ? 8'h01 : 8'h00;
        if (eng_busy != 0) eng_busy--;
      end
      default: begin
        // chip-select release keeps status and array
        eng_ptr = 24'hffffff;
        eng_st = ENG_STANDBY;
        eng_phase = 2'd0;
        eng_latch = 8'h00;
        eng_busy = 8'h00;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  // offer one request and hold it until taken; called at a falling edge
  task automatic offer(input logic [1:0] f, input logic [7:0] b, input bit typed,
                       input logic [7:0] trd, input logic tflt);
    res_t r;
    logic [7:0] prd;
    logic pflt;
    in_valid <= 1'b1;
    func <= f;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    eeprom_access(f, b, prd, pflt);
    r.read_data = typed ? trd : prd;
    r.fault = typed ? tflt : pflt;
    awaited_replies.push_back(r);
    n_requests++;
    if (pflt) n_faults++;
    @(negedge clk);
    // sender gap, valid lowered only when a gap is actually taken
    if (snd_pct != 0 && $urandom_range(0, 99) < snd_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < snd_pct);
    end
  endtask

  // send the request unless it would fetch an unwritten byte; then release instead
  task automatic issue(input logic [1:0] f, input logic [7:0] b, inout bit ok);
    if (reads_known_byte(f, b)) begin
      offer(f, b, 1'b0, 8'h00, 1'b0);
    end else begin
      ok = 1'b0;
      offer(FN_RELEASE, b, 1'b0, 8'h00, 1'b0);
    end
  endtask

  // three address bytes; the top one is random since it folds away
  task automatic send_address(input logic [15:0] a, inout bit ok);
    if (ok) issue(FN_WRITE, 8'($urandom_range(0, 255)), ok);
    if (ok) issue(FN_WRITE, a[15:8], ok);
    if (ok) issue(FN_WRITE, a[7:0], ok);
  endtask

  // write addresses crowd the bottom and the top of the array so reads find data
  function automatic logic [15:0] pick_write_addr();
    case ($urandom_range(0, 4))
      0, 1: return 16'h0000 + 16'($urandom_range(0, 63));
      2, 3: return 16'hffc0 + 16'($urandom_range(0, 63));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // lower valid and wait for every outstanding reply
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_replies.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ID_FIRST:    cfg.id_first = val;
      REG_ID_SECOND:   cfg.id_second = val;
      REG_ID_THIRD:    cfg.id_third = val;
      REG_BUSY_RELOAD: cfg.busy_reload = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // one well-formed command sequence with random content, or a little noise
  task automatic random_transaction();
    int kind;
    int n;
    bit ok;
    logic [15:0] a;
    logic [7:0] op;
    ok = 1'b1;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // array write burst, usually closed by a release
      issue(FN_WRITE, OP_ARRWR, ok);
      send_address(pick_write_addr(), ok);
      repeat ($urandom_range(1, 12)) issue(FN_WRITE, 8'($urandom_range(0, 255)), ok);
      if ($urandom_range(0, 9) != 0) issue(FN_RELEASE, 8'($urandom_range(0, 255)), ok);
    end else if (kind < 35) begin
      issue(FN_WRITE, OP_BYTEWR, ok);
      send_address(pick_write_addr(), ok);
      issue(FN_WRITE, 8'($urandom_range(0, 255)), ok);
    end else if (kind < 60) begin
      // streaming read from a written address, sometimes with an early read
      op = $urandom_range(0, 1) ? OP_READ : OP_QOFR;
      issue(FN_WRITE, op, ok);
      if (ok && $urandom_range(0, 4) == 0) issue(FN_READ, 8'($urandom_range(0, 255)), ok);
      a = wr_list[$urandom_range(0, wr_list.size() - 1)];
      send_address(a, ok);
      n = $urandom_range(1, 8);
      while (ok && n > 0) begin
        issue(FN_READ, 8'($urandom_range(0, 255)), ok);
        n--;
      end
      if (ok && $urandom_range(0, 9) != 0) issue(FN_RELEASE, 8'($urandom_range(0, 255)), ok);
    end else if (kind < 68) begin
      // id readout, sometimes running past the third byte
      issue(FN_WRITE, OP_RDID, ok);
      repeat ($urandom_range(0, 4)) issue(FN_READ, 8'($urandom_range(0, 255)), ok);
    end else if (kind < 78) begin
      case ($urandom_range(0, 3))
        0: issue(FN_WRITE, OP_WREN, ok);
        1: issue(FN_WRITE, OP_WRDI, ok);
        2: begin
          issue(FN_WRITE, OP_RDSR, ok);
          repeat ($urandom_range(1, 2)) issue(FN_READ, 8'($urandom_range(0, 255)), ok);
        end
        default: begin
          issue(FN_WRITE, OP_WRSR, ok);
          issue(FN_WRITE, 8'($urandom_range(0, 255)), ok);
        end
      endcase
    end else if (kind < 87) begin
      // busy polling, through the latch and directly
      issue(FN_WRITE, OP_LPWP, ok);
      repeat ($urandom_range(0, 3)) issue(FN_POLL, 8'($urandom_range(0, 255)), ok);
      if ($urandom_range(0, 1) != 0) issue(FN_READ, 8'($urandom_range(0, 255)), ok);
    end else begin
      repeat ($urandom_range(1, 4))
        issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), ok);
    end
  endtask

  // receiver: random stalls plus a long hold-off counted here
  initial begin
    out_ready = 1'b0;
    rcv_cycle = 0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (rcv_cycle < hold_end) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 99) >= rcv_pct);
    end
  end

  // reply checker, oldest expectation first
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with no request pending", 8'h00, read_data);
      end else begin
        if (read_data !== awaited_replies[0].read_data)
          report_mismatch("read_data", awaited_replies[0].read_data, read_data);
        if (fault !== awaited_replies[0].fault)
          report_mismatch("fault", {7'd0, awaited_replies[0].fault}, {7'd0, fault});
        void'(awaited_replies.pop_front());
        n_replies++;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int start;
    bit hold_done;
    bit pause_done;
    logic [7:0] v_first;
    logic [7:0] v_second;
    logic [7:0] v_third;
    logic [7:0] v_busy;
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_WRITE;
    data_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    snd_pct = 0;
    rcv_pct = 0;
    hold_end = 0;
    mismatch_cnt = 0;
    n_requests = 0;
    n_faults = 0;
    n_replies = 0;
    stall_cycles = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    // predictor after reset
    eng_st = ENG_STANDBY;
    eng_phase = 2'd0;
    eng_ptr = 24'hffffff;
    eng_latch = 8'h00;
    eng_busy = 8'h00;
    eng_status = 8'h00;
    cfg.id_first = ID_FIRST_RST;
    cfg.id_second = ID_SECOND_RST;
    cfg.id_third = ID_THIRD_RST;
    cfg.busy_reload = BUSY_RELOAD_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table at reset configuration, no idling
    foreach (dir_rows[i])
      offer(dir_rows[i].f, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].rd, dir_rows[i].flt);
    drain();

    // four idling phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          v_first = 8'h00; v_second = 8'h00; v_third = 8'h00; v_busy = 8'h00;
          snd_pct = 0; rcv_pct = 0;
        end
        1: begin
          v_first = 8'hff; v_second = 8'hff; v_third = 8'hff; v_busy = 8'hff;
          snd_pct = 49; rcv_pct = 0;
        end
        2: begin
          v_first = 8'($urandom_range(0, 255)); v_second = 8'($urandom_range(0, 255));
          v_third = 8'($urandom_range(0, 255)); v_busy = 8'($urandom_range(1, 3));
          snd_pct = 0; rcv_pct = 49;
        end
        default: begin
          v_first = 8'($urandom_range(0, 255)); v_second = 8'($urandom_range(0, 255));
          v_third = 8'($urandom_range(0, 255)); v_busy = 8'($urandom_range(0, 255));
          snd_pct = 28; rcv_pct = 28;
        end
      endcase
      cfg_write(REG_ID_FIRST, v_first);
      cfg_write(REG_ID_SECOND, v_second);
      cfg_write(REG_ID_THIRD, v_third);
      cfg_write(REG_BUSY_RELOAD, v_busy);

      start = n_requests;
      while (n_requests - start < PHASE_REQUESTS) begin
        random_transaction();
        // receiver holds off while requests keep coming, so the engine backs up
        if (ph == 0 && !hold_done && n_requests - start >= 40) begin
          hold_end = rcv_cycle + HOLD_CYCLES;
          hold_done = 1'b1;
        end
        // sender stops until every reply is back, mid-sequence
        if (ph == 2 && !pause_done && n_requests - start >= 60) begin
          drain();
          pause_done = 1'b1;
        end
      end
      drain();
    end

    // let any stray reply show up
    repeat (16) @(posedge clk);

    $display("covered %0d requests (%0d faulting) over four idling phases and four settings",
             n_requests, n_faults);
    $display("%0d array bytes written, %0d replies compared, %0d mismatches",
             wr_list.size(), n_replies, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
